// ----- hw/rtl/tfjq_pkg.sv -----
// Shared types and constants of the timed and FIFO job queue.
`default_nettype none
package tfjq_pkg;

	// Fixed field widths of the item formats
	localparam int ID_W     = 16;
	localparam int TIME_W   = 32;
	localparam int CNT_W    = 5;
	localparam int OPCODE_W = 2;
	localparam int STATUS_W = 2;

	// Command codes
	localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_TAKE  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Request item
	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [ID_W-1:0]     job_id;
		logic                has_time;
		logic [TIME_W-1:0]   due_time;
		logic [TIME_W-1:0]   now;
	} tfjq_req_t;

	// Response item
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     out_job_id;
		logic                from_timed;
		logic                job_ready;
		logic [CNT_W-1:0]    timed_count;
		logic [CNT_W-1:0]    fifo_count;
	} tfjq_rsp_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SHIFT,
		S_PLACE,
		S_RELOAD,
		S_DONE
	} tfjq_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_req;
		logic set_full;
		logic set_empty;
		logic fifo_push;
		logic fifo_pop;
		logic timed_pop;
		logic rd_tail;
		logic rd_next_head;
		logic scan_start;
		logic move;
		logic place_zero;
		logic place_above;
		logic head_load;
		logic rsp_load;
	} tfjq_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic                has_time;
		logic                t_full;
		logic                t_empty;
		logic                t_one;
		logic                t_due;
		logic                f_full;
		logic                f_empty;
		logic                scan_ge;
		logic                k_zero;
		logic                rsp_free;
	} tfjq_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/timed_and_fifo_job_queue.sv -----
// Top level of the timed and FIFO job queue.
// Usage:
//   req channel (req_valid/req_ready/req) carries one command item: add, take or
//   query. rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one result item
//   per command, in order, with both occupancy counts.
//   Timed jobs sit in a circular buffer sorted by due time; an add walks it from
//   the tail, moving one entry per cycle through the timed memory's single read
//   and write port. An add of a timed job to a non-empty list goes from DECIDE
//   to SHIFT, stays there while entries move, then writes the job above the
//   first earlier entry, or goes to PLACE to write it at the head, then DONE.
//   Untimed adds, adds that find their queue full or the timed list empty, FIFO
//   takes and queries go from DECIDE straight to DONE; a take from the timed list
//   passes through RELOAD when entries remain behind it (the new head is read
//   back from memory). The result is registered and loaded in DONE.
//   One command is in work at a time; req_ready is high only between commands.
//   The result sits in an output register; if the receiver stalls, the next
//   command can still be taken and runs until its own result is due, then holds.
//   Reset clears pointers and counts at once: both queues read as empty, no
//   clearing pass is needed, and no result is pending.
`default_nettype none
module timed_and_fifo_job_queue #(
	parameter int TIMED_DEPTH = 16,
	parameter int FIFO_DEPTH  = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  tfjq_pkg::tfjq_req_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output tfjq_pkg::tfjq_rsp_t  rsp
);
	import tfjq_pkg::*;

	tfjq_cmd_t  cmd;
	tfjq_stat_t stat;

	// Sequencer
	tfjq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Storage and result path
	tfjq_dp #(
		.TIMED_DEPTH(TIMED_DEPTH),
		.FIFO_DEPTH (FIFO_DEPTH),
		.TIME_BITS  (TIME_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/tfjq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tfjq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tfjq_ctrl.sv -----
// Controller state machine of the job queue: sequences add, take and query.
`default_nettype none
module tfjq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  tfjq_pkg::tfjq_stat_t  stat,
	output tfjq_pkg::tfjq_cmd_t   cmd
);
	import tfjq_pkg::*;

	tfjq_state_t state_q;
	tfjq_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				priority if (stat.opcode == OP_ADD && stat.has_time && !stat.t_full &&
					!stat.t_empty) begin
					state_d = S_SHIFT;
				end else if (stat.opcode == OP_TAKE && stat.t_due && !stat.t_one) begin
					state_d = S_RELOAD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SHIFT: begin
				priority if (!stat.scan_ge) begin
					state_d = S_DONE;
				end else if (stat.k_zero) begin
					state_d = S_PLACE;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_PLACE:  state_d = S_DONE;
			S_RELOAD: state_d = S_DONE;
			S_DONE: begin
				if (stat.rsp_free) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready    = 1'b1;
				cmd.load_req = req_valid;
			end
			S_DECIDE: begin
				priority if (stat.opcode == OP_ADD) begin
					priority if (stat.has_time) begin
						priority if (stat.t_full) begin
							cmd.set_full = 1'b1;
						end else if (stat.t_empty) begin
							cmd.place_zero = 1'b1;
						end else begin
							cmd.scan_start = 1'b1;
							cmd.rd_tail    = 1'b1;
						end
					end else if (stat.f_full) begin
						cmd.set_full = 1'b1;
					end else begin
						cmd.fifo_push = 1'b1;
					end
				end else if (stat.opcode == OP_TAKE) begin
					priority if (stat.t_due) begin
						cmd.timed_pop    = 1'b1;
						cmd.rd_next_head = 1'b1;
					end else if (!stat.f_empty) begin
						cmd.fifo_pop = 1'b1;
					end else begin
						cmd.set_empty = 1'b1;
					end
				end else begin
					// query, and the unused code, change nothing
					cmd = '0;
				end
			end
			S_SHIFT: begin
				if (stat.scan_ge) begin
					cmd.move = 1'b1;
				end else begin
					cmd.place_above = 1'b1;
				end
			end
			S_PLACE:  cmd.place_zero = 1'b1;
			S_RELOAD: cmd.head_load  = 1'b1;
			S_DONE:   cmd.rsp_load   = stat.rsp_free;
			default:  cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tfjq_dp.sv -----
// Datapath of the job queue: entry memories, pointers, counts and result register.
`default_nettype none
module tfjq_dp #(
	parameter int TIMED_DEPTH = 16,
	parameter int FIFO_DEPTH  = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tfjq_pkg::tfjq_req_t   req,
	input  tfjq_pkg::tfjq_cmd_t   cmd,
	output tfjq_pkg::tfjq_stat_t  stat,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output tfjq_pkg::tfjq_rsp_t   rsp
);
	import tfjq_pkg::*;

	localparam int TPW = $clog2(TIMED_DEPTH);
	localparam int TCW = $clog2(TIMED_DEPTH + 1);
	localparam int FPW = $clog2(FIFO_DEPTH);
	localparam int FCW = $clog2(FIFO_DEPTH + 1);
	localparam int TEW = ID_W + TIME_BITS;

	// Latched request
	logic [OPCODE_W-1:0]  op_q;
	logic [ID_W-1:0]      id_q;
	logic                 has_time_q;
	logic [TIME_BITS-1:0] due_q;
	logic [TIME_BITS-1:0] now_q;

	// Timed list: circular buffer kept in time order from its head
	logic [TPW-1:0]       t_head_q;
	logic [TCW-1:0]       t_used_q;
	logic [TPW-1:0]       k_q;
	logic [ID_W-1:0]      hd_id_q;
	logic [TIME_BITS-1:0] hd_time_q;

	// Untimed FIFO
	logic [FPW-1:0] f_head_q;
	logic [FPW-1:0] f_tail_q;
	logic [FCW-1:0] f_used_q;

	// Result being built
	logic [STATUS_W-1:0] res_status_q;
	logic [ID_W-1:0]     res_id_q;
	logic                res_from_q;

	logic       rsp_valid_q;
	tfjq_rsp_t  rsp_q;

	// Memory ports
	logic           t_we;
	logic [TPW-1:0] t_waddr;
	logic [TEW-1:0] t_wdata;
	logic [TPW-1:0] t_raddr;
	logic [TEW-1:0] t_rdata;
	logic [ID_W-1:0] f_rdata;

	logic [ID_W-1:0]      rd_id;
	logic [TIME_BITS-1:0] rd_time;
	logic [TPW-1:0]       rd_log;
	logic [TPW-1:0]       wr_log;
	logic [TPW-1:0]       k_plus;
	logic [63:0]          due64;
	logic [63:0]          now64;
	logic                 job_ready;
	logic [TCW+CNT_W-1:0] t_cnt_ext;
	logic [FCW+CNT_W-1:0] f_cnt_ext;

	// Logical position in the timed list to memory address
	function automatic logic [TPW-1:0] t_phys(input logic [TPW-1:0] head,
		input logic [TPW-1:0] l);
		logic [TPW:0] s;
		s = {1'b0, head} + {1'b0, l};
		if (s >= (TPW+1)'(TIMED_DEPTH)) s = s - (TPW+1)'(TIMED_DEPTH);
		return s[TPW-1:0];
	endfunction

	// Wrapping pointer increments
	function automatic logic [TPW-1:0] t_inc(input logic [TPW-1:0] p);
		return (p == TPW'(TIMED_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [FPW-1:0] f_inc(input logic [FPW-1:0] p);
		return (p == FPW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign due64 = {{(64-TIME_W){1'b0}}, req.due_time};
	assign now64 = {{(64-TIME_W){1'b0}}, req.now};

	assign rd_id   = t_rdata[TEW-1:TIME_BITS];
	assign rd_time = t_rdata[TIME_BITS-1:0];
	assign k_plus  = k_q + 1'b1;

	// Timed memory addressing
	always_comb begin
		priority if (cmd.rd_tail) begin
			rd_log = TPW'(t_used_q - 1'b1);
		end else if (cmd.rd_next_head) begin
			rd_log = TPW'(1);
		end else begin
			rd_log = k_q - 1'b1;
		end
		wr_log  = cmd.place_zero ? '0 : k_plus;
		t_we    = cmd.move | cmd.place_zero | cmd.place_above;
		t_wdata = cmd.move ? t_rdata : {id_q, due_q};
		t_waddr = t_phys(t_head_q, wr_log);
		t_raddr = t_phys(t_head_q, rd_log);
	end

	tfjq_ram #(
		.WIDTH(TEW),
		.DEPTH(TIMED_DEPTH)
	) u_timed_ram (
		.clk  (clk),
		.we   (t_we),
		.waddr(t_waddr),
		.wdata(t_wdata),
		.raddr(t_raddr),
		.rdata(t_rdata)
	);

	tfjq_ram #(
		.WIDTH(ID_W),
		.DEPTH(FIFO_DEPTH)
	) u_fifo_ram (
		.clk  (clk),
		.we   (cmd.fifo_push),
		.waddr(f_tail_q),
		.wdata(id_q),
		.raddr(f_head_q),
		.rdata(f_rdata)
	);

	// Request, head copy and result payload
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q         <= req.opcode;
			id_q         <= req.job_id;
			has_time_q   <= req.has_time;
			due_q        <= due64[TIME_BITS-1:0];
			now_q        <= now64[TIME_BITS-1:0];
			res_status_q <= ST_OK;
			res_id_q     <= '0;
			res_from_q   <= 1'b0;
		end
		if (cmd.set_full)  res_status_q <= ST_FULL;
		if (cmd.set_empty) res_status_q <= ST_EMPTY;
		if (cmd.timed_pop) begin
			res_id_q   <= hd_id_q;
			res_from_q <= 1'b1;
		end
		if (cmd.fifo_pop) res_id_q <= f_rdata;
		if (cmd.place_zero) begin
			hd_id_q   <= id_q;
			hd_time_q <= due_q;
		end else if (cmd.head_load) begin
			hd_id_q   <= rd_id;
			hd_time_q <= rd_time;
		end
		if (cmd.scan_start) begin
			k_q <= TPW'(t_used_q - 1'b1);
		end else if (cmd.move) begin
			k_q <= k_q - 1'b1;
		end
		if (cmd.rsp_load) rsp_q <= '{
			status:      res_status_q,
			out_job_id:  res_id_q,
			from_timed:  res_from_q,
			job_ready:   job_ready,
			timed_count: t_cnt_ext[CNT_W-1:0],
			fifo_count:  f_cnt_ext[CNT_W-1:0]
		};
	end

	// Pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_head_q    <= '0;
			t_used_q    <= '0;
			f_head_q    <= '0;
			f_tail_q    <= '0;
			f_used_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.timed_pop) begin
				t_head_q <= t_inc(t_head_q);
				t_used_q <= t_used_q - 1'b1;
			end else if (cmd.place_zero || cmd.place_above) begin
				t_used_q <= t_used_q + 1'b1;
			end
			if (cmd.fifo_push) begin
				f_tail_q <= f_inc(f_tail_q);
				f_used_q <= f_used_q + 1'b1;
			end else if (cmd.fifo_pop) begin
				f_head_q <= f_inc(f_head_q);
				f_used_q <= f_used_q - 1'b1;
			end
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Availability on the settled state, counts cut to the result width
	assign job_ready = (f_used_q != '0) || ((t_used_q != '0) && (now_q >= hd_time_q));
	assign t_cnt_ext = {{CNT_W{1'b0}}, t_used_q};
	assign f_cnt_ext = {{CNT_W{1'b0}}, f_used_q};

	// Status to the controller
	always_comb begin
		stat.opcode   = op_q;
		stat.has_time = has_time_q;
		stat.t_full   = (t_used_q == TCW'(TIMED_DEPTH));
		stat.t_empty  = (t_used_q == '0);
		stat.t_one    = (t_used_q == TCW'(1));
		stat.t_due    = (t_used_q != '0) && (now_q >= hd_time_q);
		stat.f_full   = (f_used_q == FCW'(FIFO_DEPTH));
		stat.f_empty  = (f_used_q == '0);
		stat.scan_ge  = (rd_time >= due_q);
		stat.k_zero   = (k_q == '0);
		stat.rsp_free = !rsp_valid_q || rsp_ready;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the timed and FIFO job queue: directed rows, then random traffic.
`timescale 1ns / 1ps
module tb;
	import tfjq_pkg::*;

	localparam int T_DEPTH = 16;
	localparam int F_DEPTH = 16;
	localparam int RANDOM_PER_PHASE = 175;
	localparam int DRAIN_CYCLES = 60;
	localparam int LIMIT = 400000;
	localparam int LONG_HOLD = 300;
	localparam int PLAN_ROWS = 19;
	// opcode three behaves as a query
	localparam logic [OPCODE_W-1:0] OP_RSVD = 2'd3;
	localparam logic [TIME_W-1:0] T_MAX = '1;

	typedef struct packed {
		tfjq_req_t  cmd;
		logic [5:0] reps;
		logic       fixed;
		tfjq_rsp_t  want;
	} step_row_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	tfjq_req_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	tfjq_rsp_t rsp;

	// shadow of the two queues
	logic [ID_W-1:0]   tq_id [0:T_DEPTH-1];
	logic [TIME_W-1:0] tq_due [0:T_DEPTH-1];
	int                tq_n = 0;
	logic [ID_W-1:0]   fq_id [0:F_DEPTH-1];
	int                fq_rd = 0;
	int                fq_wr = 0;
	int                fq_n = 0;

	tfjq_rsp_t   awaited[$];
	step_row_t   plan [0:PLAN_ROWS-1];
	int          mismatches = 0;
	int          tx_idle = 17;
	int          rx_idle = 81;
	int          rx_hold = 0;
	int          lean = 2;
	int          cycles = 0;
	logic [TIME_W-1:0] clock_s = 32'd1000;

	timed_and_fifo_job_queue DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic timed_is_due(input logic [TIME_W-1:0] now);
		return tq_n > 0 && now >= tq_due[0];
	endfunction

	// Apply one command to the shadow queues and return the result it gives
	function automatic tfjq_rsp_t apply_command(input tfjq_req_t c);
		tfjq_rsp_t o;
		int pos;
		o = '0;
		o.status = ST_OK;
		if (c.opcode == OP_ADD && c.has_time) begin
			if (tq_n >= T_DEPTH) begin
				o.status = ST_FULL;
			end else begin
				// sorted insert, ahead of equal due times
				pos = 0;
				while (pos < tq_n && tq_due[pos] < c.due_time)
					pos++;
				for (int k = tq_n; k > pos; k--) begin
					tq_id[k] = tq_id[k-1];
					tq_due[k] = tq_due[k-1];
				end
				tq_id[pos] = c.job_id;
				tq_due[pos] = c.due_time;
				tq_n++;
			end
		end else if (c.opcode == OP_ADD) begin
			if (fq_n >= F_DEPTH) begin
				o.status = ST_FULL;
			end else begin
				fq_id[fq_wr] = c.job_id;
				fq_wr = (fq_wr + 1) % F_DEPTH;
				fq_n++;
			end
		end else if (c.opcode == OP_TAKE) begin
			// a due timed job wins over the FIFO head
			if (timed_is_due(c.now)) begin
				o.out_job_id = tq_id[0];
				o.from_timed = 1'b1;
				for (int k = 1; k < tq_n; k++) begin
					tq_id[k-1] = tq_id[k];
					tq_due[k-1] = tq_due[k];
				end
				tq_n--;
			end else if (fq_n > 0) begin
				o.out_job_id = fq_id[fq_rd];
				fq_rd = (fq_rd + 1) % F_DEPTH;
				fq_n--;
			end else begin
				o.status = ST_EMPTY;
			end
		end
		o.job_ready = fq_n > 0 || timed_is_due(c.now);
		o.timed_count = CNT_W'(tq_n);
		o.fifo_count = CNT_W'(fq_n);
		return o;
	endfunction

	function automatic tfjq_req_t mk_cmd(input logic [OPCODE_W-1:0] op, input logic [ID_W-1:0] id,
			input logic ht, input logic [TIME_W-1:0] due, input logic [TIME_W-1:0] now);
		tfjq_req_t c;
		c.opcode = op;
		c.job_id = id;
		c.has_time = ht;
		c.due_time = due;
		c.now = now;
		return c;
	endfunction

	function automatic tfjq_rsp_t mk_rsp(input logic [STATUS_W-1:0] st, input logic [ID_W-1:0] id,
			input logic ft, input logic rdy, input int tc, input int fc);
		tfjq_rsp_t o;
		o.status = st;
		o.out_job_id = id;
		o.from_timed = ft;
		o.job_ready = rdy;
		o.timed_count = CNT_W'(tc);
		o.fifo_count = CNT_W'(fc);
		return o;
	endfunction

	function automatic step_row_t mk_row(input tfjq_req_t c, input int reps, input logic fixed,
			input tfjq_rsp_t want);
		step_row_t s;
		s.cmd = c;
		s.reps = 6'(reps);
		s.fixed = fixed;
		s.want = want;
		return s;
	endfunction

	// Random command; lean steers towards filling, draining or a mix
	function automatic tfjq_req_t rand_command();
		tfjq_req_t c;
		int roll;
		int add_pct;
		clock_s = clock_s + $urandom_range(0, 3);
		if ($urandom_range(0, 49) == 0)
			clock_s = $urandom;
		add_pct = (lean == 0) ? 70 : (lean == 1) ? 20 : 45;
		roll = $urandom_range(0, 99);
		if (roll < add_pct)
			c.opcode = OP_ADD;
		else if (roll < 92)
			c.opcode = OP_TAKE;
		else if (roll < 98)
			c.opcode = OP_QUERY;
		else
			c.opcode = OP_RSVD;
		c.job_id = ID_W'($urandom);
		c.has_time = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 15))
			0: c.due_time = $urandom;
			1: c.due_time = '0;
			2: c.due_time = T_MAX;
			default: c.due_time = clock_s + $urandom_range(0, 30) - 10;
		endcase
		case ($urandom_range(0, 15))
			0: c.now = $urandom;
			1: c.now = T_MAX;
			2: c.now = '0;
			default: c.now = clock_s;
		endcase
		return c;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("ERROR at %0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_result(input tfjq_rsp_t got);
		tfjq_rsp_t want;
		if (awaited.size() == 0) begin
			flag_mismatch($sformatf("result %h with nothing awaited", got));
		end else begin
			want = awaited.pop_front();
			if (got.status !== want.status)
				flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.out_job_id !== want.out_job_id)
				flag_mismatch($sformatf("out_job_id %h, want %h", got.out_job_id, want.out_job_id));
			if (got.from_timed !== want.from_timed)
				flag_mismatch($sformatf("from_timed %b, want %b", got.from_timed, want.from_timed));
			if (got.job_ready !== want.job_ready)
				flag_mismatch($sformatf("job_ready %b, want %b", got.job_ready, want.job_ready));
			if (got.timed_count !== want.timed_count)
				flag_mismatch($sformatf("timed_count %0d, want %0d", got.timed_count,
					want.timed_count));
			if (got.fifo_count !== want.fifo_count)
				flag_mismatch($sformatf("fifo_count %0d, want %0d", got.fifo_count,
					want.fifo_count));
		end
	endtask

	// Present one item and hold it until taken; called at a rising edge
	task automatic offer(input tfjq_req_t c, input logic fixed, input tfjq_rsp_t want);
		tfjq_rsp_t model_out;
		req <= c;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		model_out = apply_command(c);
		awaited.insert(awaited.size(), fixed ? want : model_out);
	endtask

	task automatic idle_gap();
		if ($urandom_range(0, 99) < tx_idle) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle);
		end
	endtask

	// Result side: random stalls, plus a long hold-off when asked
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready)
				check_result(rsp);
			if (rx_hold > 0) begin
				rsp_ready <= 1'b0;
				rx_hold--;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= rx_idle);
			end
		end
	end

	// Watchdog
	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int ph;
		int r;
		int n;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;

		// empty queues, unused fields, extremes of time, tie ordering, both full cases
		plan[0]  = mk_row(mk_cmd(OP_TAKE, 16'h0000, 1'b0, '0, '0), 1, 1'b1,
			mk_rsp(ST_EMPTY, 16'h0, 1'b0, 1'b0, 0, 0));
		plan[1]  = mk_row(mk_cmd(OP_QUERY, 16'hFFFF, 1'b1, T_MAX, T_MAX), 1, 1'b1,
			mk_rsp(ST_OK, 16'h0, 1'b0, 1'b0, 0, 0));
		plan[2]  = mk_row(mk_cmd(OP_RSVD, 16'hFFFF, 1'b1, T_MAX, T_MAX), 1, 1'b1,
			mk_rsp(ST_OK, 16'h0, 1'b0, 1'b0, 0, 0));
		plan[3]  = mk_row(mk_cmd(OP_ADD, 16'hFFFF, 1'b0, T_MAX, '0), 1, 1'b1,
			mk_rsp(ST_OK, 16'h0, 1'b0, 1'b1, 0, 1));
		plan[4]  = mk_row(mk_cmd(OP_ADD, 16'h0000, 1'b1, T_MAX, '0), 1, 1'b0, '0);
		plan[5]  = mk_row(mk_cmd(OP_ADD, 16'h0001, 1'b1, '0, '0), 1, 1'b0, '0);
		plan[6]  = mk_row(mk_cmd(OP_ADD, 16'h0002, 1'b1, '0, '0), 1, 1'b0, '0);
		plan[7]  = mk_row(mk_cmd(OP_TAKE, 16'hFFFF, 1'b1, T_MAX, '0), 1, 1'b0, '0);
		plan[8]  = mk_row(mk_cmd(OP_TAKE, 16'h0000, 1'b0, '0, '0), 1, 1'b0, '0);
		plan[9]  = mk_row(mk_cmd(OP_TAKE, 16'h0000, 1'b0, '0, 32'hFFFF_FFFE), 1, 1'b0, '0);
		plan[10] = mk_row(mk_cmd(OP_TAKE, 16'h0000, 1'b0, '0, 32'hFFFF_FFFE), 1, 1'b0, '0);
		plan[11] = mk_row(mk_cmd(OP_TAKE, 16'h0000, 1'b0, '0, T_MAX), 1, 1'b0, '0);
		plan[12] = mk_row(mk_cmd(OP_ADD, 16'hAAAA, 1'b0, '0, '0), F_DEPTH, 1'b0, '0);
		plan[13] = mk_row(mk_cmd(OP_ADD, 16'h5555, 1'b0, '0, '0), 1, 1'b1,
			mk_rsp(ST_FULL, 16'h0, 1'b0, 1'b1, 0, F_DEPTH));
		plan[14] = mk_row(mk_cmd(OP_ADD, 16'h5555, 1'b1, 32'd5, '0), T_DEPTH, 1'b0, '0);
		plan[15] = mk_row(mk_cmd(OP_ADD, 16'hAAAA, 1'b1, '0, '0), 1, 1'b1,
			mk_rsp(ST_FULL, 16'h0, 1'b0, 1'b1, T_DEPTH, F_DEPTH));
		plan[16] = mk_row(mk_cmd(OP_QUERY, 16'h0000, 1'b0, '0, 32'd4), 1, 1'b0, '0);
		plan[17] = mk_row(mk_cmd(OP_TAKE, 16'h0000, 1'b0, '0, T_MAX), T_DEPTH + F_DEPTH, 1'b0,
			'0);
		plan[18] = mk_row(mk_cmd(OP_TAKE, 16'h0000, 1'b0, '0, T_MAX), 1, 1'b1,
			mk_rsp(ST_EMPTY, 16'h0, 1'b0, 1'b0, 0, 0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// three idling profiles; the last one opens with a long result stall
		for (ph = 0; ph < 3; ph++) begin
			tx_idle = (ph == 0) ? 17 : (ph == 1) ? 81 : 0;
			rx_idle = (ph == 0) ? 81 : (ph == 1) ? 17 : 0;
			if (ph == 2)
				rx_hold = LONG_HOLD;
			if (ph == 0) begin
				for (r = 0; r < PLAN_ROWS; r++) begin
					for (n = 0; n < plan[r].reps; n++) begin
						idle_gap();
						offer(plan[r].cmd, plan[r].fixed, plan[r].want);
					end
				end
			end
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (n % 30 == 0)
					lean = $urandom_range(0, 2);
				idle_gap();
				offer(rand_command(), 1'b0, '0);
			end
		end
		req_valid <= 1'b0;

		// let every awaited result arrive, then watch for strays
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
